### src/phbc_pkg.sv
`timescale 1ns / 1ps

package phbc_pkg;

    // Input field widths
    localparam int CHAR_W = 8;
    localparam int PAIR_W = 2 * CHAR_W;
    localparam int REC_W  = 16;

    // Folding sum: sum stays below FOLD_MODULUS
    localparam int FOLD_MODULUS = 20000;
    localparam int SUM_W        = $clog2(FOLD_MODULUS);
    // Sum plus one pair, before reduction
    localparam int FOLD_W       = PAIR_W + 1;

    // Bucket store
    localparam int BUCKET_COUNT = 100;
    localparam int BKT_W        = $clog2(BUCKET_COUNT);
    localparam int MOD_D        = BUCKET_COUNT + 1;
    // Floor reciprocal of MOD_D scaled by 2^SUM_W; quotient estimate is low by at most one
    localparam int RECIP        = (1 << SUM_W) / MOD_D;

    // Hit counter
    localparam int HIT_W     = 15;
    localparam int HIT_LIMIT = (1 << HIT_W) - 1;

    // Queue between fold front and bucket back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [REC_W-1:0] record_id;
    } key_item_t;

    typedef struct packed {
        logic [BKT_W-1:0] bucket;
        logic             newly_claimed;
        logic [REC_W-1:0] kept_record;
        logic [HIT_W-1:0] hit_count;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_REM,
        BK_READ,
        BK_UPDATE
    } back_state_t;

endpackage

### src/plate_fold_hash_bucket_counter.sv
`timescale 1ns / 1ps

// Folding hash with a bucket hit counter.
// Input stream: one character pair per transfer; tlast marks the final pair of a
// key. Pairs fold into a running sum modulo 20000 at one pair per cycle while
// the queue is not full. On the final pair the finished sum goes into a
// four-entry queue; the bucket side takes keys from it one at a time: remainder
// by reciprocal (quotient, then index), store read, update and result load.
// Output stream: one transfer per key. The bucket side handles one key at a time
// through its four-step sequence and takes no new key before the last is done;
// keys of four or more pairs flow at one pair per cycle while the output is not
// stalled, shorter keys are limited by the bucket side's sequence per key.
// A stalled output holds its result; the bucket side waits on it, the queue fills
// and s_axis_tready drops only when the queue is full.
// Reset clears the running sum, the queue, the occupied marks and the output.
// Unoccupied buckets read as zero hits, so no clearing pass is needed.
module plate_fold_hash_bucket_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_high, [15:8] char_low, [31:16] record_id
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] bucket, [22:7] kept_record, [37:23] hit_count, [39:38] zero
    output logic [39:0] m_axis_tdata,
    // [0] newly_claimed
    output logic        m_axis_tuser
);

    phbc_pkg::key_item_t push_data;
    phbc_pkg::key_item_t pop_data;
    phbc_pkg::result_t   result;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;

    phbc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .char_high  (s_axis_tdata[7:0]),
        .char_low   (s_axis_tdata[15:8]),
        .record_id  (s_axis_tdata[31:16]),
        .last_pair  (s_axis_tlast),
        .queue_full (full),
        .queue_push (push),
        .queue_data (push_data)
    );

    phbc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    phbc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (empty),
        .queue_data  (pop_data),
        .queue_pop   (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (result)
    );

    assign m_axis_tdata = {2'b00, result.hit_count, result.kept_record, result.bucket};
    assign m_axis_tuser = result.newly_claimed;

endmodule

### src/phbc_fifo.sv
`timescale 1ns / 1ps

module phbc_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  phbc_pkg::key_item_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output phbc_pkg::key_item_t  pop_data,
    output logic                 empty
);

    phbc_pkg::key_item_t           entry_reg [phbc_pkg::QUEUE_DEPTH];
    logic [phbc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [phbc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [phbc_pkg::QPTR_W:0]     count_reg;
    logic [phbc_pkg::QPTR_W:0]     count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full     = (count_reg == (phbc_pkg::QPTR_W + 1)'(phbc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/phbc_front.sv
`timescale 1ns / 1ps

module phbc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [phbc_pkg::CHAR_W-1:0]   char_high,
    input  logic [phbc_pkg::CHAR_W-1:0]   char_low,
    input  logic [phbc_pkg::REC_W-1:0]    record_id,
    input  logic                          last_pair,
    input  logic                          queue_full,
    output logic                          queue_push,
    output phbc_pkg::key_item_t           queue_data
);

    localparam logic [phbc_pkg::FOLD_W-1:0] M1 = phbc_pkg::FOLD_W'(phbc_pkg::FOLD_MODULUS);
    localparam logic [phbc_pkg::FOLD_W-1:0] M2 = phbc_pkg::FOLD_W'(2 * phbc_pkg::FOLD_MODULUS);
    localparam logic [phbc_pkg::FOLD_W-1:0] M3 = phbc_pkg::FOLD_W'(3 * phbc_pkg::FOLD_MODULUS);
    localparam logic [phbc_pkg::FOLD_W-1:0] M4 = phbc_pkg::FOLD_W'(4 * phbc_pkg::FOLD_MODULUS);

    logic [phbc_pkg::SUM_W-1:0]  sum_reg;
    logic [phbc_pkg::SUM_W-1:0]  sum_next;
    logic [phbc_pkg::FOLD_W-1:0] total;
    logic [phbc_pkg::FOLD_W-1:0] reduced;
    logic                        take;

    assign in_ready = !queue_full;
    assign take     = in_valid && in_ready;

    // Sum plus a pair is below five moduli: pick the largest multiple that fits
    always_comb
    begin
        total = phbc_pkg::FOLD_W'(sum_reg) + phbc_pkg::FOLD_W'({char_high, char_low});
        if (total >= M4)
        begin
            reduced = total - M4;
        end
        else if (total >= M3)
        begin
            reduced = total - M3;
        end
        else if (total >= M2)
        begin
            reduced = total - M2;
        end
        else if (total >= M1)
        begin
            reduced = total - M1;
        end
        else
        begin
            reduced = total;
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (take)
        begin
            sum_next = last_pair ? '0 : reduced[phbc_pkg::SUM_W-1:0];
        end
    end

    assign queue_push           = take && last_pair;
    assign queue_data.sum       = reduced[phbc_pkg::SUM_W-1:0];
    assign queue_data.record_id = record_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

### src/phbc_back.sv
`timescale 1ns / 1ps

module phbc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  queue_empty,
    input  phbc_pkg::key_item_t   queue_data,
    output logic                  queue_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output phbc_pkg::result_t     out_data
);

    localparam int SUM_W = phbc_pkg::SUM_W;
    localparam int BKT_W = phbc_pkg::BKT_W;
    localparam int REC_W = phbc_pkg::REC_W;
    localparam int HIT_W = phbc_pkg::HIT_W;

    typedef struct packed {
        logic [REC_W-1:0] record_id;
        logic [HIT_W-1:0] hits;
    } entry_t;

    phbc_pkg::back_state_t state_reg;
    phbc_pkg::back_state_t state_next;

    entry_t                          store_mem [phbc_pkg::BUCKET_COUNT];
    logic [phbc_pkg::BUCKET_COUNT-1:0] occupied_reg;

    logic [SUM_W-1:0]   sum_reg;
    logic [REC_W-1:0]   record_reg;
    logic [SUM_W-1:0]   quot_reg;
    logic [BKT_W-1:0]   idx_reg;
    entry_t             rd_data_reg;
    logic               occ_reg;
    logic               out_valid_reg;
    phbc_pkg::result_t  out_data_reg;

    logic [2*SUM_W-1:0] quot_full;
    logic [2*SUM_W-1:0] back_full;
    logic [SUM_W-1:0]   rem_raw;
    logic [SUM_W-1:0]   rem_fix;
    logic [BKT_W-1:0]   idx_calc;

    logic               load_key;
    logic               load_idx;
    logic               do_read;
    logic               do_update;
    logic               out_free;

    entry_t             upd_entry;
    logic [HIT_W-1:0]   hits_old;
    phbc_pkg::result_t  upd_result;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and step strobes
    always_comb
    begin
        state_next = state_reg;
        load_key   = 1'b0;
        load_idx   = 1'b0;
        do_read    = 1'b0;
        do_update  = 1'b0;
        case (state_reg)
            phbc_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    load_key   = 1'b1;
                    state_next = phbc_pkg::BK_REM;
                end
            end
            phbc_pkg::BK_REM:
            begin
                load_idx   = 1'b1;
                state_next = phbc_pkg::BK_READ;
            end
            phbc_pkg::BK_READ:
            begin
                do_read    = 1'b1;
                state_next = phbc_pkg::BK_UPDATE;
            end
            phbc_pkg::BK_UPDATE:
            begin
                if (out_free)
                begin
                    do_update  = 1'b1;
                    state_next = phbc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = phbc_pkg::BK_IDLE;
            end
        endcase
    end

    assign queue_pop = load_key;

    // Quotient estimate by the reciprocal, registered before the back multiply
    assign quot_full = (2 * SUM_W)'(queue_data.sum) * (2 * SUM_W)'(phbc_pkg::RECIP);

    // Remainder modulo MOD_D with one correction, then fold MOD_D-1 onto zero
    always_comb
    begin
        back_full = (2 * SUM_W)'(quot_reg) * (2 * SUM_W)'(phbc_pkg::MOD_D);
        rem_raw   = sum_reg - back_full[SUM_W-1:0];
        if (rem_raw >= SUM_W'(phbc_pkg::MOD_D))
        begin
            rem_fix = rem_raw - SUM_W'(phbc_pkg::MOD_D);
        end
        else
        begin
            rem_fix = rem_raw;
        end
        if (rem_fix == SUM_W'(phbc_pkg::BUCKET_COUNT))
        begin
            idx_calc = '0;
        end
        else
        begin
            idx_calc = rem_fix[BKT_W-1:0];
        end
    end

    // An empty bucket reads as zero hits and takes the new record
    always_comb
    begin
        hits_old            = occ_reg ? rd_data_reg.hits : '0;
        upd_entry.record_id = occ_reg ? rd_data_reg.record_id : record_reg;
        if (hits_old == HIT_W'(phbc_pkg::HIT_LIMIT))
        begin
            upd_entry.hits = hits_old;
        end
        else
        begin
            upd_entry.hits = hits_old + 1'b1;
        end
        upd_result.bucket        = idx_reg;
        upd_result.newly_claimed = !occ_reg;
        upd_result.kept_record   = upd_entry.record_id;
        upd_result.hit_count     = upd_entry.hits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phbc_pkg::BK_IDLE;
            occupied_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_update)
            begin
                occupied_reg[idx_reg] <= 1'b1;
                out_valid_reg         <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_key)
        begin
            sum_reg    <= queue_data.sum;
            record_reg <= queue_data.record_id;
            quot_reg   <= quot_full[2*SUM_W-1:SUM_W];
        end
        if (load_idx)
        begin
            idx_reg <= idx_calc;
        end
        if (do_read)
        begin
            rd_data_reg <= store_mem[idx_reg];
            occ_reg     <= occupied_reg[idx_reg];
        end
        if (do_update)
        begin
            store_mem[idx_reg] <= upd_entry;
            out_data_reg       <= upd_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.hit_count != '0))
        else $error("result with zero hit count");

    a_claim_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.newly_claimed) |-> (out_data_reg.hit_count == HIT_W'(1)))
        else $error("claimed bucket with hit count other than one");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.bucket < BKT_W'(phbc_pkg::BUCKET_COUNT)))
        else $error("bucket index out of range");

    a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == phbc_pkg::BK_READ) |=> (state_reg == phbc_pkg::BK_UPDATE))
        else $error("read not followed by update");

endmodule
